// ===== hw/rtl/nirenc_pkg.sv =====
// Shared types and constants for the NEC IR frame encoder.
package nirenc_pkg;

    // Register widths
    localparam int KeyW   = 8;
    localparam int CycW   = 10;
    localparam int UsW    = 14;
    localparam int IdxW   = 3;
    localparam int BitCntW = 3;

    // Reset values of the configuration registers
    localparam logic [KeyW-1:0] XorKeyRst      = 8'hAA;
    localparam logic [CycW-1:0] BitBurstRst    = 10'd21;
    localparam logic [CycW-1:0] LeaderBurstRst = 10'd346;
    localparam logic [UsW-1:0]  ZeroSpaceRst   = 14'd562;
    localparam logic [UsW-1:0]  OneSpaceRst    = 14'd1687;
    localparam logic [UsW-1:0]  LeaderSpaceRst = 14'd4500;

    // Configuration register indexes
    typedef enum logic [IdxW-1:0] {
        REG_XOR_KEY      = 3'd0,
        REG_BIT_BURST    = 3'd1,
        REG_LEADER_BURST = 3'd2,
        REG_ZERO_SPACE   = 3'd3,
        REG_ONE_SPACE    = 3'd4,
        REG_LEADER_SPACE = 3'd5
    } reg_idx_t;

    // Segment kinds on the output
    typedef enum logic [2:0] {
        KIND_LEADER_BURST = 3'd0,
        KIND_LEADER_SPACE = 3'd1,
        KIND_BIT_BURST    = 3'd2,
        KIND_ZERO_SPACE   = 3'd3,
        KIND_ONE_SPACE    = 3'd4,
        KIND_STOP_BURST   = 3'd5
    } seg_kind_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAD_BURST,
        ST_LEAD_SPACE,
        ST_BIT_BURST,
        ST_BIT_SPACE,
        ST_STOP
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      accept;
        logic      emit;
        logic      bit_adv;
        logic      seg_last;
        seg_kind_t kind;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic cur_bit;
        logic bit_done;
        logic last_flag;
    } dp_status_t;

endpackage

// ===== hw/rtl/nec_ir_frame_encoder_top.sv =====
// NEC IR frame encoder: takes one message byte per transaction and emits
// its IR line segments (leader, eight bit burst/space pairs, stop) one per
// transaction on the output. A byte yields 16 to 19 segments. The block
// first accepts the byte, then, while the output does not stall, moves
// one segment per cycle from the controller into the single output
// register. The input stalls while a byte is being sequenced and opens
// again once its final segment is registered, even if that segment still
// waits on the output. Lengths come from the configuration registers as
// they stand while the byte is sequenced, so write them only while idle.
module nec_ir_frame_encoder_top
    import nirenc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [IdxW-1:0] cfg_index,
    input  logic [UsW-1:0]  cfg_data,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      data_byte,
    input  logic            first_byte,
    input  logic            last_byte,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      segment_kind,
    output logic            carrier_on,
    output logic [UsW-1:0]  seg_length,
    output logic            last_segment
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer
    nirenc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .first_byte (first_byte),
        .status     (status),
        .in_stall   (in_stall),
        .cmd        (cmd)
    );

    // Datapath
    nirenc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .cmd          (cmd),
        .out_stall    (out_stall),
        .status       (status),
        .out_valid    (out_valid),
        .segment_kind (segment_kind),
        .carrier_on   (carrier_on),
        .seg_length   (seg_length),
        .last_segment (last_segment)
    );

endmodule

// ===== hw/rtl/nirenc_ctrl.sv =====
// Sequencer state machine: walks leader, data bits and stop segments.
module nirenc_ctrl
    import nirenc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       first_byte,
    input  dp_status_t status,
    output logic       in_stall,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.emit     = 1'b0;
        cmd.bit_adv  = 1'b0;
        cmd.seg_last = 1'b0;
        cmd.kind     = KIND_BIT_BURST;
        in_stall     = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = first_byte ? ST_LEAD_BURST : ST_BIT_BURST;
                end
            end
            ST_LEAD_BURST:
            begin
                cmd.kind = KIND_LEADER_BURST;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_LEAD_SPACE;
                end
            end
            ST_LEAD_SPACE:
            begin
                cmd.kind = KIND_LEADER_SPACE;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_BIT_BURST;
                end
            end
            ST_BIT_BURST:
            begin
                cmd.kind = KIND_BIT_BURST;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_BIT_SPACE;
                end
            end
            ST_BIT_SPACE:
            begin
                cmd.kind = status.cur_bit ? KIND_ONE_SPACE : KIND_ZERO_SPACE;
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.bit_adv = 1'b1;
                    if (!status.bit_done)
                    begin
                        state_next = ST_BIT_BURST;
                    end
                    else if (status.last_flag)
                    begin
                        state_next = ST_STOP;
                    end
                    else
                    begin
                        cmd.seg_last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_STOP:
            begin
                cmd.kind = KIND_STOP_BURST;
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.seg_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/nirenc_dp.sv =====
// Datapath: config registers, keyed byte, bit counter and output register.
module nirenc_dp
    import nirenc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IdxW-1:0]  cfg_index,
    input  logic [UsW-1:0]   cfg_data,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  ctrl_cmd_t        cmd,
    input  logic             out_stall,
    output dp_status_t       status,
    output logic             out_valid,
    output logic [2:0]       segment_kind,
    output logic             carrier_on,
    output logic [UsW-1:0]   seg_length,
    output logic             last_segment
);

    logic [KeyW-1:0]    xor_key_reg;
    logic [CycW-1:0]    bit_burst_reg;
    logic [CycW-1:0]    leader_burst_reg;
    logic [UsW-1:0]     zero_space_reg;
    logic [UsW-1:0]     one_space_reg;
    logic [UsW-1:0]     leader_space_reg;

    logic [7:0]         byte_reg;
    logic               last_reg;
    logic [BitCntW-1:0] bit_cnt_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    seg_kind_t          kind_reg;
    logic               carrier_reg;
    logic [UsW-1:0]     length_reg;
    logic               seg_last_reg;

    logic [UsW-1:0]     length_next;
    logic               carrier_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_key_reg      <= XorKeyRst;
            bit_burst_reg    <= BitBurstRst;
            leader_burst_reg <= LeaderBurstRst;
            zero_space_reg   <= ZeroSpaceRst;
            one_space_reg    <= OneSpaceRst;
            leader_space_reg <= LeaderSpaceRst;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_XOR_KEY:      xor_key_reg      <= cfg_data[KeyW-1:0];
                REG_BIT_BURST:    bit_burst_reg    <= cfg_data[CycW-1:0];
                REG_LEADER_BURST: leader_burst_reg <= cfg_data[CycW-1:0];
                REG_ZERO_SPACE:   zero_space_reg   <= cfg_data;
                REG_ONE_SPACE:    one_space_reg    <= cfg_data;
                REG_LEADER_SPACE: leader_space_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Keyed byte, stop flag and bit counter (MSB first)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '1;
        end
        else if (cmd.accept)
        begin
            bit_cnt_reg <= '1;
        end
        else if (cmd.bit_adv)
        begin
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= data_byte ^ xor_key_reg;
            last_reg <= last_byte;
        end
    end

    // Segment length and carrier select
    always_comb
    begin
        case (cmd.kind)
            KIND_LEADER_BURST:
            begin
                length_next  = {{(UsW-CycW){1'b0}}, leader_burst_reg};
                carrier_next = 1'b1;
            end
            KIND_LEADER_SPACE:
            begin
                length_next  = leader_space_reg;
                carrier_next = 1'b0;
            end
            KIND_ZERO_SPACE:
            begin
                length_next  = zero_space_reg;
                carrier_next = 1'b0;
            end
            KIND_ONE_SPACE:
            begin
                length_next  = one_space_reg;
                carrier_next = 1'b0;
            end
            default:
            begin
                // bit burst and stop burst share one length
                length_next  = {{(UsW-CycW){1'b0}}, bit_burst_reg};
                carrier_next = 1'b1;
            end
        endcase
    end

    // Output register
    assign out_valid_next = cmd.emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg     <= cmd.kind;
            carrier_reg  <= carrier_next;
            length_reg   <= length_next;
            seg_last_reg <= cmd.seg_last;
        end
    end

    // Status back to the controller
    assign status.out_free  = !out_valid_reg || !out_stall;
    assign status.cur_bit   = byte_reg[bit_cnt_reg];
    assign status.bit_done  = (bit_cnt_reg == '0);
    assign status.last_flag = last_reg;

    assign out_valid    = out_valid_reg;
    assign segment_kind = kind_reg;
    assign carrier_on   = carrier_reg;
    assign seg_length   = length_reg;
    assign last_segment = seg_last_reg;

endmodule

// ===== hw/rtl/nirenc_checker.sv =====
// Port-level checks for the NEC IR frame encoder, bound to the top level.
module nirenc_checker
    import nirenc_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_stall,
    input logic            out_valid,
    input logic            out_stall,
    input logic [2:0]      segment_kind,
    input logic            carrier_on,
    input logic [UsW-1:0]  seg_length,
    input logic            last_segment
);

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(segment_kind)
            && $stable(seg_length) && $stable(last_segment))
        else $error("stalled output changed");

    // An accepted byte keeps the input busy while it is sequenced
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    // Spaces never carry the carrier, bursts always do
    a_carrier_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> carrier_on == (segment_kind == KIND_LEADER_BURST
            || segment_kind == KIND_BIT_BURST || segment_kind == KIND_STOP_BURST))
        else $error("carrier flag does not match segment kind");

    // A byte's final segment is never a leader or a bit burst
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_segment |-> segment_kind == KIND_STOP_BURST
            || segment_kind == KIND_ZERO_SPACE || segment_kind == KIND_ONE_SPACE)
        else $error("final segment of a byte has wrong kind");

endmodule

bind nec_ir_frame_encoder_top nirenc_checker u_nirenc_checker (.*);
